// ----- src/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, codes and reset values for the buzzer pattern sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

   localparam int TICK_W = 16;
   localparam int PAT_W = 2;
   localparam int CODE_W = 3;
   localparam int IDX_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam int PULSE_COUNT_DEF = 3;

   localparam logic [TICK_W-1:0] LONG_TICKS_RST = 16'd2000;
   localparam logic [TICK_W-1:0] SHORT_TICKS_RST = 16'd300;
   localparam logic [TICK_W-1:0] STEP_TICKS_RST = 16'd100;

   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_EVENT = 1'b1
   } action_type;

   typedef enum logic [PAT_W-1:0] {
      PAT_LONG = 2'd0,
      PAT_SHORT = 2'd1,
      PAT_TRIPLE = 2'd2,
      PAT_SETUP = 2'd3
   } pattern_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LONG_TICKS = 2'd0,
      CSR_SHORT_TICKS = 2'd1,
      CSR_STEP_TICKS = 2'd2,
      CSR_UNUSED = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [TICK_W-1:0] long_ticks;
      logic [TICK_W-1:0] short_ticks;
      logic [TICK_W-1:0] step_ticks;
   } timing_cfg_type;

   typedef struct packed {
      pattern_type pattern;
      logic [IDX_W-1:0] index;
   } phase_req_type;

endpackage

`default_nettype wire

// ----- src/bps_req_if.sv -----
// ----------------------------------------------------------------------------
// bps_req_if
// Request channel: one tick or pattern event per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bps_req_if;
   logic valid;
   logic ready;
   logic action;
   logic [bps_pkg::CODE_W-1:0] pattern_code;

   modport source (output valid, output action, output pattern_code, input ready);
   modport sink (input valid, input action, input pattern_code, output ready);
endinterface

`default_nettype wire

// ----- src/bps_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bps_rsp_if
// Response channel: buzzer level and busy flag, one transfer per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bps_rsp_if;
   logic valid;
   logic ready;
   logic buzzer_on;
   logic busy_res;

   modport source (output valid, output buzzer_on, output busy_res, input ready);
   modport sink (input valid, input buzzer_on, input busy_res, output ready);
endinterface

`default_nettype wire

// ----- src/bps_phase_calc.sv -----
// ----------------------------------------------------------------------------
// bps_phase_calc
// Phase duration in ticks for a pattern and pulse index, clamped to >= 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bps_phase_calc (
   input  wire bps_pkg::timing_cfg_type cfg,
   input  wire bps_pkg::phase_req_type  req,
   output logic [bps_pkg::TICK_W-1:0]   ticks
);

   localparam int CUT_W = bps_pkg::TICK_W + 2;

   logic [CUT_W-1:0] cut;
   logic [CUT_W-1:0] short_ext;
   logic [bps_pkg::TICK_W-1:0] dur;

   // step * index, index is at most 3
   always_comb begin
      cut = (req.index[0] ? CUT_W'(cfg.step_ticks) : '0)
          + (req.index[1] ? CUT_W'({cfg.step_ticks, 1'b0}) : '0);
      short_ext = CUT_W'(cfg.short_ticks);
   end

   always_comb begin
      unique case (req.pattern)
         bps_pkg::PAT_LONG: begin
            dur = cfg.long_ticks;
         end
         bps_pkg::PAT_SETUP: begin
            dur = (cut >= short_ext) ? '0 : cfg.short_ticks - cut[bps_pkg::TICK_W-1:0];
         end
         default: begin
            dur = cfg.short_ticks;
         end
      endcase
      ticks = (dur == '0) ? bps_pkg::TICK_W'(1) : dur;
   end

endmodule

`default_nettype wire

// ----- src/buzzer_pattern_sequencer.sv -----
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer
// Steps beep patterns on ticks and events; reports buzzer level and busy.
//
//   Port       Dir   Width  Transfer
//   req_chan   in    1+3    valid & ready: action, pattern_code
//   rsp_chan   out   1+1    valid & ready: buzzer_on, busy_res
//   csr_*      in    2+16   csr_write: csr_index, csr_data
//
// One request per cycle unless the response is stalled; its response is valid on the next cycle.
// The sequencer state and response flag are one register stage.
// A new request is taken while the response slot is empty or being drained.
// Synchronous reset: idle, buzzer off, timing registers at 2000/300/100.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module buzzer_pattern_sequencer #(
   parameter int PULSE_COUNT = bps_pkg::PULSE_COUNT_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   bps_req_if.sink                            req_chan,
   bps_rsp_if.source                          rsp_chan,
   input  wire                                csr_write,
   input  wire [bps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [bps_pkg::TICK_W-1:0]          csr_data
);

   localparam int TW = bps_pkg::TICK_W;
   localparam int IW = bps_pkg::IDX_W;
   localparam logic [IW:0] PULSES = (IW+1)'(PULSE_COUNT);

   bps_pkg::timing_cfg_type cfg_ff;
   bps_pkg::pattern_type    pattern_ff, pattern_in;
   logic                    playing_ff, playing_in;
   logic [IW-1:0]           index_ff, index_in;
   logic                    level_ff, level_in;
   logic [TW-1:0]           ticks_ff, ticks_in;
   logic                    rsp_valid_ff;

   logic                    req_xfer;
   logic                    is_event;
   logic [IW:0]             next_index;
   logic [IW:0]             pulses;
   bps_pkg::phase_req_type  phase_req;
   logic [TW-1:0]           phase_ticks;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign is_event = (req_chan.action == bps_pkg::ACT_EVENT);

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.buzzer_on = level_ff;
   assign rsp_chan.busy_res = playing_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_ticks <= bps_pkg::LONG_TICKS_RST;
         cfg_ff.short_ticks <= bps_pkg::SHORT_TICKS_RST;
         cfg_ff.step_ticks <= bps_pkg::STEP_TICKS_RST;
      end else if (csr_write) begin
         unique case (bps_pkg::csr_index_type'(csr_index))
            bps_pkg::CSR_LONG_TICKS:  cfg_ff.long_ticks <= csr_data;
            bps_pkg::CSR_SHORT_TICKS: cfg_ff.short_ticks <= csr_data;
            bps_pkg::CSR_STEP_TICKS:  cfg_ff.step_ticks <= csr_data;
            default: ;
         endcase
      end
   end

   assign next_index = {1'b0, index_ff} + (IW+1)'(1);
   assign pulses = (pattern_ff == bps_pkg::PAT_TRIPLE || pattern_ff == bps_pkg::PAT_SETUP)
                 ? PULSES : (IW+1)'(1);

   always_comb begin
      if (is_event) begin
         phase_req.pattern = bps_pkg::pattern_type'(req_chan.pattern_code[bps_pkg::PAT_W-1:0]);
         phase_req.index = '0;
      end else if (level_ff) begin
         phase_req.pattern = pattern_ff;
         phase_req.index = index_ff;
      end else begin
         phase_req.pattern = pattern_ff;
         phase_req.index = next_index[IW-1:0];
      end
   end

   bps_phase_calc u_phase (
      .cfg   (cfg_ff),
      .req   (phase_req),
      .ticks (phase_ticks)
   );

   always_comb begin
      pattern_in = pattern_ff;
      playing_in = playing_ff;
      index_in = index_ff;
      level_in = level_ff;
      ticks_in = ticks_ff;
      priority if (is_event) begin
         if (!req_chan.pattern_code[bps_pkg::CODE_W-1]) begin
            pattern_in = phase_req.pattern;
            playing_in = 1'b1;
            index_in = '0;
            level_in = 1'b1;
            ticks_in = phase_ticks;
         end else begin
            playing_in = 1'b0;
         end
      end else if (playing_ff) begin
         priority if (ticks_ff > TW'(1)) begin
            ticks_in = ticks_ff - TW'(1);
         end else if (level_ff) begin
            level_in = 1'b0;
            ticks_in = phase_ticks;
         end else if (next_index < pulses) begin
            index_in = next_index[IW-1:0];
            level_in = 1'b1;
            ticks_in = phase_ticks;
         end else begin
            playing_in = 1'b0;
            ticks_in = '0;
         end
      end else begin
         // tick while idle: hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= bps_pkg::PAT_LONG;
         playing_ff <= 1'b0;
         index_ff <= '0;
         level_ff <= 1'b0;
         ticks_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            pattern_ff <= pattern_in;
            playing_ff <= playing_in;
            index_ff <= index_in;
            level_ff <= level_in;
            ticks_ff <= ticks_in;
         end
         if (req_xfer) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_playing_has_ticks: assert property (@(posedge clock) disable iff (reset)
      playing_ff |-> ticks_ff != '0)
      else $error("playing with zero ticks left");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      playing_ff |-> {1'b0, index_ff} < pulses)
      else $error("pulse index beyond pattern length");

   a_single_pulse_index: assert property (@(posedge clock) disable iff (reset)
      (playing_ff && (pattern_ff == bps_pkg::PAT_LONG || pattern_ff == bps_pkg::PAT_SHORT))
      |-> index_ff == '0)
      else $error("single pulse pattern past first pulse");

   a_event_starts_on: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && is_event && !req_chan.pattern_code[bps_pkg::CODE_W-1])
      |=> (rsp_valid_ff && level_ff && playing_ff))
      else $error("known event did not start pattern with buzzer on");

   a_unknown_holds_level: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && is_event && req_chan.pattern_code[bps_pkg::CODE_W-1])
      |=> (!playing_ff && level_ff == $past(level_ff)))
      else $error("unknown code changed level or kept playing");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the buzzer pattern sequencer.
// A cycle-level predictor follows every accepted tick or pattern event and
// queues the buzzer level and busy flag that should come back. A checker
// compares each response transfer, in order, against that queue. Directed
// tests cover reset timing, unknown codes, cut-off patterns and duration
// clamping; random tests then play whole and broken patterns under a range
// of small and extreme timing settings, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int PULSES = bps_pkg::PULSE_COUNT_DEF;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_WAIT = 12;

   typedef struct packed {
      logic buzzer_on;
      logic busy;
   } beep_status_type;

   logic clock;
   logic reset;
   logic csr_write;
   bps_pkg::csr_index_type csr_index;
   logic [bps_pkg::TICK_W-1:0] csr_data;

   bps_req_if req_bus ();
   bps_rsp_if rsp_bus ();

   buzzer_pattern_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // predictor state and timing registers
   logic [bps_pkg::TICK_W-1:0] cfg_long;
   logic [bps_pkg::TICK_W-1:0] cfg_short;
   logic [bps_pkg::TICK_W-1:0] cfg_step;
   bps_pkg::pattern_type run_pat;
   bit run_on;
   logic [bps_pkg::IDX_W-1:0] pulse_no;
   bit buzz_level;
   logic [bps_pkg::TICK_W-1:0] phase_left;

   beep_status_type expected_status[$];

   int unsigned error_count;
   int unsigned requests_sent;
   int unsigned events_sent;
   int unsigned results_checked;
   int unsigned timing_settings;
   int unsigned quiet_cycles;
   int unsigned rsp_stall;
   bit sender_paced;
   bit receiver_paced;

   always #5 clock = ~clock;

   function automatic int unsigned draw_wait(bit paced);
      return paced ? $urandom_range(0, MAX_WAIT) : 0;
   endfunction

   function automatic logic [bps_pkg::TICK_W-1:0] phase_ticks(bps_pkg::pattern_type pat,
                                                              logic [bps_pkg::IDX_W-1:0] idx);
      logic [31:0] cut;
      logic [31:0] span;
      if (pat == bps_pkg::PAT_LONG) begin
         span = 32'(cfg_long);
      end else if (pat == bps_pkg::PAT_SETUP) begin
         cut = 32'(cfg_step) * 32'(idx);
         span = (cut >= 32'(cfg_short)) ? 32'd0 : 32'(cfg_short) - cut;
      end else begin
         span = 32'(cfg_short);
      end
      return (span == 0) ? bps_pkg::TICK_W'(1) : span[bps_pkg::TICK_W-1:0];
   endfunction

   function automatic int unsigned pulse_total(bps_pkg::pattern_type pat);
      return (pat == bps_pkg::PAT_TRIPLE || pat == bps_pkg::PAT_SETUP) ? PULSES : 1;
   endfunction

   // ticks needed after the event for the pattern to run out
   function automatic int unsigned pattern_span(bps_pkg::pattern_type pat);
      int unsigned sum;
      sum = 0;
      for (int i = 0; i < pulse_total(pat); i++)
         sum += 2 * phase_ticks(pat, bps_pkg::IDX_W'(i));
      return sum;
   endfunction

   function automatic beep_status_type advance_sequencer(bps_pkg::action_type act,
                                                         logic [bps_pkg::CODE_W-1:0] code);
      int unsigned next_pulse;
      if (act == bps_pkg::ACT_EVENT) begin
         if (code <= 3) begin
            run_pat = bps_pkg::pattern_type'(code[bps_pkg::PAT_W-1:0]);
            run_on = 1'b1;
            pulse_no = '0;
            buzz_level = 1'b1;
            phase_left = phase_ticks(run_pat, '0);
         end else begin
            run_on = 1'b0;
         end
      end else if (run_on) begin
         if (phase_left > 1) begin
            phase_left = phase_left - 1'b1;
         end else if (buzz_level) begin
            buzz_level = 1'b0;
            phase_left = phase_ticks(run_pat, pulse_no);
         end else begin
            next_pulse = pulse_no + 1;
            if (next_pulse < pulse_total(run_pat)) begin
               pulse_no = next_pulse[bps_pkg::IDX_W-1:0];
               buzz_level = 1'b1;
               phase_left = phase_ticks(run_pat, pulse_no);
            end else begin
               run_on = 1'b0;
               phase_left = '0;
            end
         end
      end
      return '{buzzer_on: buzz_level, busy: run_on};
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      $display("mismatch at response %0d: %s", results_checked, what);
   endtask

   task automatic send_request(bps_pkg::action_type act, logic [bps_pkg::CODE_W-1:0] code);
      int unsigned gap;
      gap = draw_wait(sender_paced);
      if (gap != 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.pattern_code <= code;
      do begin
         @(posedge clock);
      end while (req_bus.ready !== 1'b1);
      expected_status.push_back(advance_sequencer(act, code));
      requests_sent++;
      if (act == bps_pkg::ACT_EVENT)
         events_sent++;
   endtask

   task automatic settle_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_status.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(bps_pkg::csr_index_type idx, logic [bps_pkg::TICK_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         bps_pkg::CSR_LONG_TICKS: cfg_long = value;
         bps_pkg::CSR_SHORT_TICKS: cfg_short = value;
         bps_pkg::CSR_STEP_TICKS: cfg_step = value;
         default: ;
      endcase
   endtask

   task automatic apply_timing(logic [bps_pkg::TICK_W-1:0] long_v,
                               logic [bps_pkg::TICK_W-1:0] short_v,
                               logic [bps_pkg::TICK_W-1:0] step_v);
      settle_idle();
      write_reg(bps_pkg::CSR_LONG_TICKS, long_v);
      write_reg(bps_pkg::CSR_SHORT_TICKS, short_v);
      write_reg(bps_pkg::CSR_STEP_TICKS, step_v);
      timing_settings++;
   endtask

   task automatic send_ticks(int unsigned count);
      repeat (count) send_request(bps_pkg::ACT_TICK, bps_pkg::CODE_W'($urandom));
   endtask

   // mostly complete or cut patterns, with unknown codes and idle ticks mixed in
   task automatic play_random(int unsigned n_items);
      int unsigned start;
      int unsigned pick;
      int unsigned span;
      int unsigned n_ticks;
      logic [bps_pkg::CODE_W-1:0] code;
      start = requests_sent;
      while (requests_sent - start < n_items) begin
         sender_paced = ($urandom_range(0, 3) != 0);
         receiver_paced = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            code = bps_pkg::CODE_W'($urandom_range(0, 3));
            span = pattern_span(bps_pkg::pattern_type'(code[bps_pkg::PAT_W-1:0]));
            if (span > 40)
               span = 40;
            n_ticks = ($urandom_range(0, 9) < 7) ? span + $urandom_range(0, 2)
                                                 : $urandom_range(0, span);
            send_request(bps_pkg::ACT_EVENT, code);
            send_ticks(n_ticks);
         end else if (pick < 90) begin
            send_request(bps_pkg::ACT_EVENT, bps_pkg::CODE_W'($urandom_range(4, 7)));
         end else begin
            send_ticks($urandom_range(1, 4));
         end
      end
   endtask

   task automatic test_reset_timing();
      sender_paced = 1'b1;
      receiver_paced = 1'b1;
      send_request(bps_pkg::ACT_TICK, 3'd0);
      send_request(bps_pkg::ACT_EVENT, 3'd7);
      send_request(bps_pkg::ACT_EVENT, bps_pkg::CODE_W'(bps_pkg::PAT_SHORT));
      send_ticks(2);
      // unknown code while on: stops, buzzer left on
      send_request(bps_pkg::ACT_EVENT, 3'd4);
      send_request(bps_pkg::ACT_TICK, 3'd5);
      send_request(bps_pkg::ACT_EVENT, bps_pkg::CODE_W'(bps_pkg::PAT_LONG));
      send_request(bps_pkg::ACT_TICK, 3'd2);
      send_request(bps_pkg::ACT_EVENT, bps_pkg::CODE_W'(bps_pkg::PAT_TRIPLE));
      send_request(bps_pkg::ACT_EVENT, bps_pkg::CODE_W'(bps_pkg::PAT_SETUP));
      send_request(bps_pkg::ACT_EVENT, 3'd6);
   endtask

   task automatic test_duration_clamp();
      sender_paced = 1'b0;
      receiver_paced = 1'b0;
      apply_timing(16'd1, 16'd1, 16'hFFFF);
      send_request(bps_pkg::ACT_EVENT, bps_pkg::CODE_W'(bps_pkg::PAT_SETUP));
      send_ticks(7);
      send_request(bps_pkg::ACT_EVENT, bps_pkg::CODE_W'(bps_pkg::PAT_LONG));
      send_ticks(2);
   endtask

   task automatic test_short_timings();
      repeat (6) begin
         apply_timing(bps_pkg::TICK_W'($urandom_range(1, 8)),
                      bps_pkg::TICK_W'($urandom_range(1, 6)),
                      bps_pkg::TICK_W'($urandom_range(0, 4)));
         play_random(180);
      end
   endtask

   task automatic test_extreme_timings();
      apply_timing(16'hFFFF, 16'hFFFF, 16'd0);
      play_random(120);
      apply_timing(16'd1, 16'd1, 16'd0);
      play_random(120);
      apply_timing(16'd3, 16'hFFFF, 16'hFFFF);
      play_random(120);
      // step lands exactly on short at the last pulse
      apply_timing(16'd2, 16'd4, 16'd2);
      play_random(120);
      apply_timing(16'd5, 16'd5, 16'hFFFF);
      play_random(120);
   endtask

   always @(posedge clock) begin
      beep_status_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_checked++;
         if (expected_status.size() == 0) begin
            report_mismatch("response transfer with no request outstanding");
         end else begin
            want = expected_status.pop_front();
            if (rsp_bus.buzzer_on !== want.buzzer_on)
               report_mismatch($sformatf("buzzer_on %b, expected %b",
                                         rsp_bus.buzzer_on, want.buzzer_on));
            if (rsp_bus.busy_res !== want.busy)
               report_mismatch($sformatf("busy_res %b, expected %b",
                                         rsp_bus.busy_res, want.busy));
         end
         rsp_stall = draw_wait(receiver_paced);
      end
   end

   always @(negedge clock) begin
      if (rsp_stall != 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
          || (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("buzzer_pattern_sequencer regression: fail");
            $finish;
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = bps_pkg::CSR_LONG_TICKS;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.action = bps_pkg::ACT_TICK;
      req_bus.pattern_code = '0;
      rsp_bus.ready = 1'b0;
      rsp_stall = 0;
      quiet_cycles = 0;
      error_count = 0;
      requests_sent = 0;
      events_sent = 0;
      results_checked = 0;
      timing_settings = 1;
      sender_paced = 1'b1;
      receiver_paced = 1'b1;
      cfg_long = bps_pkg::LONG_TICKS_RST;
      cfg_short = bps_pkg::SHORT_TICKS_RST;
      cfg_step = bps_pkg::STEP_TICKS_RST;
      run_pat = bps_pkg::PAT_LONG;
      run_on = 1'b0;
      pulse_no = '0;
      buzz_level = 1'b0;
      phase_left = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_timing();
      test_duration_clamp();
      test_short_timings();
      test_extreme_timings();

      settle_idle();
      repeat (4) @(posedge clock);
      $display("covered %0d requests (%0d pattern events) across %0d timing settings",
               requests_sent, events_sent, timing_settings);
      $display("checked %0d responses, %0d mismatches", results_checked, error_count);
      if (error_count == 0) begin
         $display("buzzer_pattern_sequencer regression: pass");
      end else begin
         $display("buzzer_pattern_sequencer regression: fail");
      end
      $finish;
   end

endmodule
